>>> rtl/core/npl_pkg.sv
// Shared types, widths and helpers for the nearest point and path length block.
package npl_pkg;

    localparam int COORD_W        = 16;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int SQ_W           = 2 * DIFF_W;
    localparam int ROOT_W         = SQ_W / 2;
    localparam int INDEX_W        = 8;
    localparam int DIST_W         = 17;
    localparam int SUM_W          = 25;
    localparam int CFG_IDX_W      = 1;
    localparam int MAX_POINTS_DEF = 256;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = 1'b1;

    typedef enum logic [1:0] {
        KIND_FIRST,
        KIND_NORM,
        KIND_SKIP
    } t_kind;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      is_last;
    } t_in;

    typedef struct packed {
        logic [INDEX_W-1:0] nearest_index;
        logic [DIST_W-1:0]  nearest_distance;
        logic [SUM_W-1:0]   path_length;
    } t_out;

    typedef struct packed {
        t_kind           kind;
        logic            last;
        logic [SQ_W-1:0] sq_query;
        logic [SQ_W-1:0] sq_seg;
    } t_job;

    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic [DIFF_W-1:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
    endfunction

endpackage

>>> rtl/core/npl_front.sv
// Front end: query registers, point classification and squared distances.
module npl_front #(
    parameter int MAX_POINTS = npl_pkg::MAX_POINTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [npl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [npl_pkg::COORD_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  npl_pkg::t_in                      i_in_data,
    output logic                              o_push,
    output npl_pkg::t_job                     o_job,
    input  logic                              i_full
);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_PUSH
    } t_state;

    t_state                               r_state;
    logic signed [npl_pkg::COORD_W-1:0]   r_query_x;
    logic signed [npl_pkg::COORD_W-1:0]   r_query_y;
    logic signed [npl_pkg::COORD_W-1:0]   r_prev_x;
    logic signed [npl_pkg::COORD_W-1:0]   r_prev_y;
    logic [CNT_W-1:0]                     r_count;
    logic [npl_pkg::DIFF_W-1:0]           r_dqx, r_dqy, r_dpx, r_dpy;
    logic [npl_pkg::SQ_W-1:0]             r_pqx, r_pqy, r_ppx, r_ppy;
    npl_pkg::t_kind                       r_kind;
    logic                                 r_last;

    logic                                 w_accept;
    npl_pkg::t_kind                       w_kind;

    always_comb begin
        w_accept = i_in_valid && (r_state == S_IDLE);
        if (r_count >= CNT_W'(MAX_POINTS)) begin
            w_kind = npl_pkg::KIND_SKIP;
        end else if (r_count == '0) begin
            w_kind = npl_pkg::KIND_FIRST;
        end else begin
            w_kind = npl_pkg::KIND_NORM;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_push         = (r_state == S_PUSH) && !i_full;
    assign o_job.kind     = r_kind;
    assign o_job.last     = r_last;
    assign o_job.sq_query = r_pqx + r_pqy;
    assign o_job.sq_seg   = r_ppx + r_ppy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_query_x <= '0;
            r_query_y <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    npl_pkg::REG_QUERY_X: r_query_x <= i_cfg_data;
                    npl_pkg::REG_QUERY_Y: r_query_y <= i_cfg_data;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_dqx  <= npl_pkg::abs_diff(i_in_data.point_x, r_query_x);
                        r_dqy  <= npl_pkg::abs_diff(i_in_data.point_y, r_query_y);
                        r_dpx  <= npl_pkg::abs_diff(i_in_data.point_x, r_prev_x);
                        r_dpy  <= npl_pkg::abs_diff(i_in_data.point_y, r_prev_y);
                        r_kind <= w_kind;
                        r_last <= i_in_data.is_last;
                        if (i_in_data.is_last) begin
                            r_count  <= '0;
                            r_prev_x <= '0;
                            r_prev_y <= '0;
                        end else if (w_kind != npl_pkg::KIND_SKIP) begin
                            r_count  <= r_count + CNT_W'(1);
                            r_prev_x <= i_in_data.point_x;
                            r_prev_y <= i_in_data.point_y;
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_pqx   <= r_dqx * r_dqx;
                    r_pqy   <= r_dqy * r_dqy;
                    r_ppx   <= r_dpx * r_dpx;
                    r_ppy   <= r_dpy * r_dpy;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/core/npl_queue.sv
// Two-entry request queue between the front end and the back end.
module npl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  npl_pkg::t_job i_data,
    input  logic          i_pop,
    output npl_pkg::t_job o_data,
    output logic          o_full,
    output logic          o_empty
);
    npl_pkg::t_job                      r_mem [npl_pkg::QUEUE_DEPTH];
    logic [npl_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr;
    logic [npl_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr;
    logic [npl_pkg::QUEUE_CNT_W-1:0]    r_count;

    assign o_full  = (r_count == npl_pkg::QUEUE_CNT_W'(npl_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + npl_pkg::QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + npl_pkg::QUEUE_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + npl_pkg::QUEUE_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - npl_pkg::QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/core/npl_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
module npl_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [npl_pkg::SQ_W-1:0]     i_radicand,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [npl_pkg::ROOT_W-1:0]   o_root
);
    localparam int REM_W = npl_pkg::ROOT_W + 2;
    localparam int CNT_W = $clog2(npl_pkg::ROOT_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_count;
    logic [npl_pkg::SQ_W-1:0]      r_rad;
    logic [REM_W-1:0]              r_rem;
    logic [npl_pkg::ROOT_W-1:0]    r_root;

    logic [REM_W-1:0]              w_shift;
    logic [REM_W-1:0]              w_trial;
    logic                          w_take;

    always_comb begin
        w_shift = {r_rem[REM_W-3:0], r_rad[npl_pkg::SQ_W-1 -: 2]};
        w_trial = {r_root, 2'b01};
        w_take  = (w_shift >= w_trial);
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start && (r_count == CNT_W'(npl_pkg::ROOT_W - 1));
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
                r_rad   <= i_radicand;
                r_rem   <= '0;
                r_root  <= '0;
            end else if (r_busy) begin
                r_rad   <= {r_rad[npl_pkg::SQ_W-3:0], 2'b00};
                r_rem   <= w_take ? (w_shift - w_trial) : w_shift;
                r_root  <= {r_root[npl_pkg::ROOT_W-2:0], w_take};
                r_count <= r_count + CNT_W'(1);
                if (r_count == CNT_W'(npl_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

>>> rtl/core/npl_back.sv
// Back end: running minimum, path sum, square roots and the result register.
module npl_back #(
    parameter int MAX_POINTS = npl_pkg::MAX_POINTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  npl_pkg::t_job  i_job,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output npl_pkg::t_out  o_out_data
);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEG,
        S_DIST_GO,
        S_DIST,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [npl_pkg::SQ_W-1:0]        r_best_square;
    logic [CNT_W-1:0]                r_best_slot;
    logic [CNT_W-1:0]                r_seen;
    logic [npl_pkg::SUM_W-1:0]       r_length;
    logic [npl_pkg::ROOT_W-1:0]      r_dist;
    logic                            r_last;
    logic                            r_out_valid;
    npl_pkg::t_out                   r_out_data;

    logic                            w_start;
    logic [npl_pkg::SQ_W-1:0]        w_radicand;
    logic                            w_busy;
    logic                            w_done;
    logic [npl_pkg::ROOT_W-1:0]      w_root;
    logic [npl_pkg::SUM_W:0]         w_sum;
    logic [npl_pkg::SUM_W-1:0]       w_length_next;
    logic                            w_out_free;

    npl_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_radicand (w_radicand),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .o_root     (w_root)
    );

    always_comb begin
        o_pop         = (r_state == S_IDLE) && !i_empty;
        w_start       = (o_pop && (i_job.kind == npl_pkg::KIND_NORM))
                        || (r_state == S_DIST_GO);
        w_radicand    = (r_state == S_DIST_GO) ? r_best_square : i_job.sq_seg;
        w_sum         = {1'b0, r_length} + (npl_pkg::SUM_W + 1)'(w_root);
        w_length_next = w_sum[npl_pkg::SUM_W] ? '1 : w_sum[npl_pkg::SUM_W-1:0];
        w_out_free    = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_best_square <= '0;
            r_best_slot   <= '0;
            r_seen        <= '0;
            r_length      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_last <= i_job.last;
                        unique case (i_job.kind)
                            npl_pkg::KIND_FIRST: begin
                                r_best_square <= i_job.sq_query;
                                r_best_slot   <= '0;
                                r_seen        <= CNT_W'(1);
                                r_state       <= i_job.last ? S_DIST_GO : S_IDLE;
                            end
                            npl_pkg::KIND_NORM: begin
                                if (i_job.sq_query < r_best_square) begin
                                    r_best_square <= i_job.sq_query;
                                    r_best_slot   <= r_seen;
                                end
                                r_seen  <= r_seen + CNT_W'(1);
                                r_state <= S_SEG;
                            end
                            npl_pkg::KIND_SKIP: begin
                                r_state <= i_job.last ? S_DIST_GO : S_IDLE;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SEG: begin
                    if (w_done) begin
                        r_length <= w_length_next;
                        r_state  <= r_last ? S_DIST_GO : S_IDLE;
                    end
                end
                S_DIST_GO: begin
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    if (w_done) begin
                        r_dist  <= w_root;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid                 <= 1'b1;
                        r_out_data.nearest_index    <= npl_pkg::INDEX_W'(r_best_slot);
                        r_out_data.nearest_distance <= npl_pkg::DIST_W'(r_dist);
                        r_out_data.path_length      <= r_length;
                        r_best_square               <= '0;
                        r_best_slot                 <= '0;
                        r_seen                      <= '0;
                        r_length                    <= '0;
                        r_state                     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !w_busy)
        else $error("square root started while busy");

    a_wait_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEG || r_state == S_DIST) |-> (w_busy || w_done))
        else $error("waiting on an idle square root unit");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside the output state");

endmodule

>>> rtl/core/nearest_point_and_path_length_top.sv
// Top level of the nearest point and path length block.
// A point passes through the front end and then the back end: the front end
// registers the coordinate differences, squares them and queues the request,
// and the back end pops it and runs the segment length through the shared square
// root unit in 17 steps of two radicand bits. The first point of a set and points
// beyond MAX_POINTS skip the square root. The point marked last adds a second
// pass through the same unit for the nearest distance before the result is
// loaded into the output register. A two-entry queue lets the front end take new
// points while the back end is busy.
module nearest_point_and_path_length_top #(
    parameter int MAX_POINTS = npl_pkg::MAX_POINTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [npl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [npl_pkg::COORD_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  npl_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output npl_pkg::t_out                  o_out_data
);
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    npl_pkg::t_job w_job_in;
    npl_pkg::t_job w_job_out;

    npl_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_push      (w_push),
        .o_job       (w_job_in),
        .i_full      (w_full)
    );

    npl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    npl_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job_out),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> dv/npl_result_checker.sv
// Checker that predicts and compares the summaries of the nearest point and path length block.
module npl_result_checker
    import npl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in                  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out                 i_out_data,
    output int                   o_failures,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [SUM_W-1:0] SUM_CAP = '1;

    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
    logic signed [COORD_W-1:0] last_x;
    logic signed [COORD_W-1:0] last_y;
    logic [SQ_W-1:0]           best_square;
    int                        best_slot;
    int                        points_seen;
    logic [SUM_W-1:0]          length_sum;
    t_out                      expected_summaries[$];
    int                        failures;

    function automatic logic [SQ_W-1:0] square_distance(
        input logic signed [COORD_W-1:0] ax,
        input logic signed [COORD_W-1:0] ay,
        input logic signed [COORD_W-1:0] bx,
        input logic signed [COORD_W-1:0] by
    );
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return SQ_W'(dx * dx + dy * dy);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        for (int b = 18; b >= 0; b--) begin
            probe = root | (64'd1 << b);
            if (probe * probe <= v) root = probe;
        end
        return root;
    endfunction

    function automatic void clear_set();
        best_square = '0;
        best_slot   = 0;
        points_seen = 0;
        last_x      = '0;
        last_y      = '0;
        length_sum  = '0;
    endfunction

    function automatic void absorb_point(input t_in p);
        logic [SQ_W-1:0] sq;
        longint unsigned total;
        t_out            summary;
        if (points_seen < MAX_POINTS_DEF) begin
            sq = square_distance(p.point_x, p.point_y, query_x, query_y);
            if (points_seen == 0) begin
                best_square = sq;
                best_slot   = 0;
            end else begin
                total = longint'(length_sum) +
                        floor_sqrt(square_distance(p.point_x, p.point_y, last_x, last_y));
                length_sum = (total > SUM_CAP) ? SUM_CAP : SUM_W'(total);
                if (sq < best_square) begin
                    best_square = sq;
                    best_slot   = points_seen;
                end
            end
            last_x = p.point_x;
            last_y = p.point_y;
            points_seen++;
        end
        if (p.is_last) begin
            summary.nearest_index    = INDEX_W'(best_slot);
            summary.nearest_distance = DIST_W'(floor_sqrt(best_square));
            summary.path_length      = length_sum;
            expected_summaries.push_back(summary);
            clear_set();
        end
    endfunction

    function automatic void note_mismatch(input string what, input t_out want, input t_out got);
        failures++;
        if (failures <= 10) begin
            $display("%0t: %s: expected index %0d dist %0d length %0d, got index %0d dist %0d length %0d",
                     $time, what, want.nearest_index, want.nearest_distance, want.path_length,
                     got.nearest_index, got.nearest_distance, got.path_length);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            query_x = '0;
            query_y = '0;
            clear_set();
            expected_summaries.delete();
            failures = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_QUERY_X: query_x = i_cfg_data;
                    REG_QUERY_Y: query_y = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) absorb_point(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (expected_summaries.size() == 0) begin
                    note_mismatch("unexpected summary", '0, i_out_data);
                end else begin
                    want = expected_summaries.pop_front();
                    if (want.nearest_index !== i_out_data.nearest_index ||
                        want.nearest_distance !== i_out_data.nearest_distance ||
                        want.path_length !== i_out_data.path_length) begin
                        note_mismatch("summary mismatch", want, i_out_data);
                    end
                end
            end
        end
        o_failures <= failures;
        o_pending  <= expected_summaries.size();
    end

endmodule

>>> dv/nearest_point_and_path_length_top_tb.sv
// Testbench top: drives point sets and query settings into the block and reports the verdict.
module nearest_point_and_path_length_top_tb;
    import npl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_POINTS  = 380;
    localparam int LONG_SET      = 265;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_QUERY_X;
    logic [COORD_W-1:0]   cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in                  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out                 out_data;

    int failures;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    bit hold_go       = 1'b0;
    bit hold_on       = 1'b0;

    logic signed [COORD_W-1:0] cur_qx = '0;
    logic signed [COORD_W-1:0] cur_qy = '0;
    logic signed [COORD_W-1:0] prev_x = '0;
    logic signed [COORD_W-1:0] prev_y = '0;

    nearest_point_and_path_length_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    npl_result_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        forever begin
            @(negedge clk);
            out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // hold the result side off so the block backs up into its input
    initial begin
        wait (hold_go);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic last);
        t_in req;
        req.point_x = x;
        req.point_y = y;
        req.is_last = last;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        prev_x = x;
        prev_y = y;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_query(input logic [COORD_W-1:0] qx, input logic [COORD_W-1:0] qy);
        write_reg(REG_QUERY_X, qx);
        write_reg(REG_QUERY_Y, qy);
        cur_qx = qx;
        cur_qy = qy;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [COORD_W-1:0] corner_value();
        case ($urandom_range(3))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'hffff;
        endcase
    endfunction

    task automatic send_set(input int count);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(7))
                0, 1: begin
                    x = corner_value();
                    y = corner_value();
                end
                2: begin
                    x = cur_qx + COORD_W'($urandom_range(64)) - COORD_W'(32);
                    y = cur_qy + COORD_W'($urandom_range(64)) - COORD_W'(32);
                end
                3: begin
                    x = prev_x;
                    y = prev_y;
                end
                default: begin
                    x = COORD_W'($urandom);
                    y = COORD_W'($urandom);
                end
            endcase
            send_point(x, y, i == count - 1);
        end
    endtask

    // zigzag between far corners: long path, and points past the set limit
    task automatic send_long_set();
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        for (int i = 0; i < LONG_SET; i++) begin
            x = i[0] ? 16'h7fff : 16'h8000;
            y = i[1] ? 16'h7fff : 16'h8000;
            if ($urandom_range(15) == 0) x = COORD_W'($urandom);
            send_point(x, y, i == LONG_SET - 1);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct,
                             input logic [COORD_W-1:0] qx, input logic [COORD_W-1:0] qy,
                             input bit with_long, input bit with_hold);
        int sent;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_query(qx, qy);
        if (with_long) send_long_set();
        sent = 0;
        while (sent < PHASE_POINTS) begin
            int n;
            n = $urandom_range(1, 12);
            send_set(n);
            sent += n;
            if (with_hold && sent >= 50) hold_go = 1'b1;
        end
        drain();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 9;
        recv_idle_pct = 70;
        write_query(16'h0000, 16'h0000);

        send_point(16'h7fff, 16'h7fff, 1'b1);
        send_point(16'h8000, 16'h8000, 1'b1);
        send_point(16'h8000, 16'h7fff, 1'b0);
        send_point(16'h7fff, 16'h8000, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h7fff, 16'h7fff, 1'b1);
        send_point(16'h0010, 16'h0000, 1'b0);
        send_point(16'h0000, 16'h0010, 1'b0);
        send_point(16'hfff0, 16'h0000, 1'b0);
        send_point(16'h0000, 16'hfff0, 1'b1);
        send_point(16'h0064, 16'h0064, 1'b0);
        send_point(16'h0032, 16'h0032, 1'b0);
        send_point(16'h0032, 16'h0032, 1'b0);
        send_point(16'h0000, 16'h0001, 1'b1);
        send_point(16'h0000, 16'h0000, 1'b1);
        send_point(16'h5555, 16'haaaa, 1'b0);
        send_point(16'haaaa, 16'h5555, 1'b1);
        drain();

        run_phase(9, 70, 16'h8000, 16'h7fff, 1'b1, 1'b0);
        run_phase(70, 9, 16'h7fff, 16'h8000, 1'b0, 1'b0);
        run_phase(0, 0, COORD_W'($urandom), COORD_W'($urandom), 1'b0, 1'b1);

        if (failures == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
